>>> rtl/hgn1d_pkg.sv
// shared types and constants for the 1d hashed gradient noise core
package hgn1d_pkg;

  localparam int NUM_STAGES = 7;
  localparam int POS_W      = 32;
  localparam int SEED_W     = 32;
  localparam int HASH_W     = 32;
  localparam int GRAD_W     = 24;
  localparam int NOISE_W    = 18;

  localparam int NOISE_MAX  = 131071;
  localparam int NOISE_MIN  = -131072;

  localparam logic [HASH_W-1:0] HASH_MUL_A = 32'h7feb352d;
  localparam logic [HASH_W-1:0] HASH_MUL_B = 32'h846ca68b;

  // one load enable per pipeline register stage
  typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

>>> rtl/hashed_gradient_noise_1d_core.sv
// top level of the 1d hashed gradient noise core
//
// Input channel (in_valid / in_ready) carries a signed fixed-point position
// with FRAC_BITS fraction bits and a 32-bit seed. Output channel
// (out_valid / out_ready) carries one signed Q1.17 noise sample per input
// beat, saturated to 18 bits, in the order the beats were taken.
//
// There are seven register stages. out_valid rises once an accepted beat has
// passed through all seven; the sample leaves on an edge with out_ready high.
// A new beat is taken every cycle while out_ready stays high; the stage count
// comes from balancing the hash multiplies, the fade products, the dot products
// and the blend so that no stage holds more than one multiplier in series.
//
// Reset empties the pipeline; the data registers are not reset. When the
// receiver stalls, stages fill up behind the output register one by one and
// in_ready falls only once every stage holds a beat, so nothing is dropped
// or repeated.
module hashed_gradient_noise_1d_core
  import hgn1d_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [POS_W-1:0]   position,
  input  logic [SEED_W-1:0]         seed,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [NOISE_W-1:0] noise
);

  stage_en_t                vld;
  stage_en_t                vld_in;
  stage_en_t                en;
  logic [HASH_W-1:0]        cell0;
  logic [HASH_W-1:0]        cell1;
  logic [FRAC_BITS-1:0]     t_s2;
  logic [FRAC_BITS:0]       fade;
  logic signed [GRAD_W-1:0] g0;
  logic signed [GRAD_W-1:0] g1;

  always_comb begin
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      if (i == NUM_STAGES - 1) begin
        en[i] = !vld[i] || out_ready;
      end else begin
        en[i] = !vld[i] || en[i+1];
      end
    end
  end

  assign vld_in = {vld[NUM_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NUM_STAGES-1];

  // floor cell and its upper neighbour, wrapping at the top cell
  assign cell0 = HASH_W'(position >>> FRAC_BITS);
  assign cell1 = cell0 + HASH_W'(1);

  hgn1d_hash u_hash0 (
    .clk    (clk),
    .en     (en),
    .corner (cell0),
    .seed   (seed),
    .grad   (g0)
  );

  hgn1d_hash u_hash1 (
    .clk    (clk),
    .en     (en),
    .corner (cell1),
    .seed   (seed),
    .grad   (g1)
  );

  hgn1d_fade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fade (
    .clk  (clk),
    .en   (en),
    .t_in (position[FRAC_BITS-1:0]),
    .t_s2 (t_s2),
    .fade (fade)
  );

  hgn1d_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk   (clk),
    .en    (en),
    .t_s2  (t_s2),
    .g0    (g0),
    .g1    (g1),
    .fade  (fade),
    .noise (noise)
  );

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  a_backpressure_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ((&vld) && !out_ready))
    else $error("input stalled while pipeline has room");

  a_beat_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted beat missing from first stage");
`endif

endmodule

>>> rtl/hgn1d_hash.sv
// three-stage xor-shift-multiply lattice hash giving a signed gradient
module hgn1d_hash
  import hgn1d_pkg::*;
(
  input  logic                     clk,
  input  stage_en_t                en,
  input  logic [HASH_W-1:0]        corner,
  input  logic [SEED_W-1:0]        seed,
  output logic signed [GRAD_W-1:0] grad
);

  logic [HASH_W-1:0] mix_s0;
  logic [HASH_W-1:0] prod_s1;
  logic [HASH_W-1:0] prod_s2;
  logic [HASH_W-1:0] x_next;
  logic [HASH_W-1:0] y_next;
  logic [HASH_W-1:0] z_fin;

  always_comb begin
    x_next = corner ^ seed;
    x_next = x_next ^ (x_next >> 16);
    y_next = prod_s1 ^ (prod_s1 >> 15);
    z_fin  = prod_s2 ^ (prod_s2 >> 16);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mix_s0 <= x_next;
    end
    if (en[1]) begin
      prod_s1 <= mix_s0 * HASH_MUL_A;
    end
    if (en[2]) begin
      prod_s2 <= y_next * HASH_MUL_B;
    end
  end

  // low 24 bits minus half range: flip the top bit
  assign grad = $signed({~z_fin[GRAD_W-1], z_fin[GRAD_W-2:0]});

endmodule

>>> rtl/hgn1d_fade.sv
// five-stage quintic fade curve of the cell fraction
module hgn1d_fade
  import hgn1d_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic                 clk,
  input  stage_en_t            en,
  input  logic [FRAC_BITS-1:0] t_in,
  output logic [FRAC_BITS-1:0] t_s2,
  output logic [FRAC_BITS:0]   fade
);

  localparam int F = FRAC_BITS;
  localparam logic [F+3:0] U_BASE = (F+4)'(15 * (1 << F));
  localparam logic [F+3:0] B_BASE = (F+4)'(10 * (1 << F));
  localparam logic [F+3:0] ONE_W  = (F+4)'(1 << F);

  logic [F-1:0]   t_s0;
  logic [F-1:0]   t_s1;
  logic [2*F-1:0] tt_s0;
  logic [F+3:0]   u_s0;
  logic [F-1:0]   t2_s1;
  logic [2*F+3:0] tu_s1;
  logic [F+3:0]   b_s2;
  logic [2*F-1:0] t3p_s2;
  logic [2*F+3:0] fp_s3;
  logic [F+3:0]   u_next;
  logic [F+3:0]   b_next;
  logic [F+3:0]   fq;
  logic [F:0]     fade_next;

  always_comb begin
    u_next = U_BASE - ((F+4)'(t_in) * (F+4)'(6));
    b_next = B_BASE - tu_s1[2*F+3:F];
    fq     = fp_s3[2*F+3:F];
    // truncated curve can overshoot one
    if (fq > ONE_W) begin
      fade_next = ONE_W[F:0];
    end else begin
      fade_next = fq[F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_s0  <= t_in;
      tt_s0 <= (2*F)'(t_in) * (2*F)'(t_in);
      u_s0  <= u_next;
    end
    if (en[1]) begin
      t_s1  <= t_s0;
      t2_s1 <= tt_s0[2*F-1:F];
      tu_s1 <= (2*F+4)'(t_s0) * (2*F+4)'(u_s0);
    end
    if (en[2]) begin
      t_s2   <= t_s1;
      b_s2   <= b_next;
      t3p_s2 <= (2*F)'(t2_s1) * (2*F)'(t_s1);
    end
    if (en[3]) begin
      fp_s3 <= (2*F+4)'(t3p_s2[2*F-1:F]) * (2*F+4)'(b_s2);
    end
    if (en[4]) begin
      fade <= fade_next;
    end
  end

endmodule

>>> rtl/hgn1d_blend.sv
// gradient dot products, fade blend, scaling and saturation
module hgn1d_blend
  import hgn1d_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic                      clk,
  input  stage_en_t                 en,
  input  logic [FRAC_BITS-1:0]      t_s2,
  input  logic signed [GRAD_W-1:0]  g0,
  input  logic signed [GRAD_W-1:0]  g1,
  input  logic [FRAC_BITS:0]        fade,
  output logic signed [NOISE_W-1:0] noise
);

  localparam int F   = FRAC_BITS;
  localparam int PW  = GRAD_W + F + 1;
  localparam int DW  = F + 2;
  localparam int MW  = 2 * F + 4;
  localparam int VW  = 2 * F + 6;
  localparam int SH  = 2 * F - 17;
  localparam int SHR = (SH > 0) ? SH : 0;
  localparam int SHL = (SH > 0) ? 0 : -SH;
  localparam logic signed [PW-1:0] RND_G  = PW'(1 << (GRAD_W - 2));
  localparam logic signed [VW-1:0] RND_V  = (SHR > 0) ? VW'(1 << (SHR - 1)) : '0;
  localparam logic [F:0]           ONE_F  = (F+1)'(1 << F);
  localparam logic signed [VW-1:0] SAT_HI = VW'(NOISE_MAX);
  localparam logic signed [VW-1:0] SAT_LO = VW'(NOISE_MIN);

  logic signed [PW-1:0]      gt0_s3;
  logic signed [PW-1:0]      gt1_s3;
  logic signed [DW-1:0]      d0_s4;
  logic signed [DW-1:0]      d1_s4;
  logic signed [MW-1:0]      pr0_s5;
  logic signed [MW-1:0]      pr1_s5;
  logic [F:0]                omf;
  logic signed [VW-1:0]      msum;
  logic signed [VW-1:0]      scaled;
  logic signed [NOISE_W-1:0] noise_next;

  always_comb begin
    omf    = ONE_F - fade;
    msum   = VW'(pr0_s5) + VW'(pr1_s5);
    scaled = ((msum + RND_V) >>> SHR) <<< SHL;
    if (scaled > SAT_HI) begin
      noise_next = NOISE_W'(NOISE_MAX);
    end else if (scaled < SAT_LO) begin
      noise_next = NOISE_W'(NOISE_MIN);
    end else begin
      noise_next = scaled[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      gt0_s3 <= PW'(g0) * PW'($signed({1'b0, t_s2}));
      // t - 1 as a negative fraction
      gt1_s3 <= PW'(g1) * PW'($signed({1'b1, t_s2}));
    end
    if (en[4]) begin
      d0_s4 <= DW'((gt0_s3 + RND_G) >>> (GRAD_W - 1));
      d1_s4 <= DW'((gt1_s3 + RND_G) >>> (GRAD_W - 1));
    end
    if (en[5]) begin
      pr0_s5 <= MW'(d0_s4) * MW'($signed({1'b0, omf}));
      pr1_s5 <= MW'(d1_s4) * MW'($signed({1'b0, fade}));
    end
    if (en[6]) begin
      noise <= noise_next;
    end
  end

endmodule
